>>> rtl/wsce_pkg.sv
// Package with the request, result and table entry types and the keep score function.
package wsce_pkg;

   localparam int SCORE_W = 48;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] CSR_BYTE_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_POLICY_MODE = 2'd1;

   localparam logic [1:0] MODE_AGGRESSIVE   = 2'd1;
   localparam logic [1:0] MODE_CONSERVATIVE = 2'd2;

   localparam logic [2:0] REASON_PREFETCH = 3'd3;

   localparam logic [39:0] BYTES_MAX = 40'hFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]        operation;
      logic [31:0]       entry_tag;
      logic [39:0]       entry_bytes;
      logic [2:0]        reason_code;
      logic [15:0]       times_played;
      logic signed [7:0] keep_priority;
      logic [33:0]       used_seconds;
      logic [33:0]       modified_seconds;
      logic              was_played;
      logic [33:0]       now_seconds;
   } req_type;

   typedef struct packed {
      logic [31:0] victim_tag;
      logic        victim_valid;
      logic        last_of_run;
      logic [39:0] bytes_left;
   } rsp_type;

   typedef struct packed {
      logic [31:0]       tag;
      logic [39:0]       bytes;
      logic [2:0]        reason;
      logic [4:0]        plays;
      logic signed [7:0] prio;
      logic [33:0]       used_t;
      logic [33:0]       mod_t;
      logic              played;
   } entry_type;

   function automatic logic [6:0] reason_weight(input logic [2:0] reason);
      logic [6:0] w;
      case (reason)
         3'd0:    w = 7'd120;
         3'd1:    w = 7'd100;
         3'd2:    w = 7'd55;
         3'd3:    w = 7'd30;
         default: w = 7'd20;
      endcase
      return w;
   endfunction

   // Keep score scaled by 72000 so every term is an exact integer.
   function automatic logic signed [SCORE_W-1:0] score_of(input entry_type e,
                                                         input logic [33:0] now,
                                                         input logic [1:0] mode);
      logic [33:0]               ref_t;
      logic [33:0]               age;
      logic signed [SCORE_W-1:0] w_t;
      logic signed [SCORE_W-1:0] m_t;
      logic signed [SCORE_W-1:0] a_t;
      logic signed [SCORE_W-1:0] s;
      ref_t = (e.used_t != 34'd0) ? e.used_t : e.mod_t;
      age   = (now > ref_t) ? now - ref_t : 34'd0;
      w_t   = SCORE_W'(reason_weight(e.reason));
      if (mode == MODE_AGGRESSIVE) begin
         m_t = SCORE_W'(27);
      end else if (mode == MODE_CONSERVATIVE) begin
         m_t = SCORE_W'(15);
      end else begin
         m_t = SCORE_W'(20);
      end
      a_t = SCORE_W'(age);
      s = w_t * m_t * SCORE_W'(3600);
      s = s + SCORE_W'(e.plays) * SCORE_W'(2520000);
      s = s + SCORE_W'(e.prio) * SCORE_W'(864000);
      if (e.played) begin
         s = s + SCORE_W'(6480000);
      end
      if (e.reason == REASON_PREFETCH && e.plays == 5'd0) begin
         s = s - SCORE_W'(5760000);
      end
      if (mode == MODE_AGGRESSIVE) begin
         s = s - ((a_t <<< 3) - a_t);
      end else begin
         s = s - ((a_t <<< 4) - a_t);
      end
      return s;
   endfunction

endpackage

>>> rtl/wsce_ram.sv
// Generic single write, single read RAM with a registered read port.
module wsce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/weighted_score_cache_evictor.sv
// Weighted score cache evictor: entry table in RAM, scan for the lowest score, compaction.
// Load and clear requests finish without leaving idle; a load into a full table is dropped.
// A run that evicts nothing returns its result in the cycle after the request; no result is held.
// Each eviction scans every slot below the high mark: the slots written since the last clear or compaction.
// After the last eviction a compaction pass closes the holes before the block returns to idle.
// Synchronous reset empties the table and clears the control registers; RAM contents are not cleared.
module weighted_score_cache_evictor #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  wsce_pkg::req_type req_data,
   output logic             rsp_valid,
   output wsce_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [47:0]      csr_wdata
);

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int TW = 40 + CW;
   localparam int EW = $bits(wsce_pkg::entry_type);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SCAN    = 2'd1;
   localparam logic [1:0] ST_EVICT   = 2'd2;
   localparam logic [1:0] ST_COMPACT = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [47:0] limit_ff, limit_in;
   logic [1:0]  mode_ff, mode_in;
   logic [MAX_ENTRIES-1:0] live_ff, live_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] wr_ff, wr_in;
   logic [TW-1:0] total_ff, total_in;
   logic [33:0]   now_ff, now_in;

   logic          p1_valid_ff, p1_valid_in;
   logic [IW-1:0] p1_idx_ff, p1_idx_in;

   logic          s2_valid_ff, s2_valid_in;
   logic [IW-1:0] s2_idx_ff, s2_idx_in;
   logic signed [wsce_pkg::SCORE_W-1:0] s2_score_ff, s2_score_in;
   logic [33:0]   s2_mt_ff, s2_mt_in;
   logic [31:0]   s2_tag_ff, s2_tag_in;
   logic [39:0]   s2_bytes_ff, s2_bytes_in;

   logic          have_best_ff, have_best_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic signed [wsce_pkg::SCORE_W-1:0] best_score_ff, best_score_in;
   logic [33:0]   best_mt_ff, best_mt_in;
   logic [31:0]   best_tag_ff, best_tag_in;
   logic [39:0]   best_bytes_ff, best_bytes_in;

   logic              rsp_valid_ff, rsp_valid_in;
   wsce_pkg::rsp_type rsp_ff, rsp_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   logic [IW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata;
   wsce_pkg::entry_type rd_entry;
   wsce_pkg::entry_type ld_entry;
   logic [TW-1:0] total_after;

   assign rd_entry = wsce_pkg::entry_type'(ram_rdata);

   wsce_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      ld_entry.tag    = req_data.entry_tag;
      ld_entry.bytes  = req_data.entry_bytes;
      ld_entry.reason = req_data.reason_code;
      ld_entry.plays  = (req_data.times_played > 16'd20) ? 5'd20 : req_data.times_played[4:0];
      ld_entry.prio   = req_data.keep_priority;
      ld_entry.used_t = req_data.used_seconds;
      ld_entry.mod_t  = req_data.modified_seconds;
      ld_entry.played = req_data.was_played;
   end

   function automatic logic [39:0] sat_bytes(input logic [TW-1:0] t);
      return (t > TW'(wsce_pkg::BYTES_MAX)) ? wsce_pkg::BYTES_MAX : t[39:0];
   endfunction

   always_comb begin
      state_in      = state_ff;
      limit_in      = limit_ff;
      mode_in       = mode_ff;
      live_in       = live_ff;
      hi_in         = hi_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      total_in      = total_ff;
      now_in        = now_ff;
      p1_valid_in   = 1'b0;
      p1_idx_in     = rd_ff[IW-1:0];
      s2_valid_in   = 1'b0;
      s2_idx_in     = p1_idx_ff;
      s2_score_in   = wsce_pkg::score_of(rd_entry, now_ff, mode_ff);
      s2_mt_in      = rd_entry.mod_t;
      s2_tag_in     = rd_entry.tag;
      s2_bytes_in   = rd_entry.bytes;
      have_best_in  = have_best_ff;
      best_idx_in   = best_idx_ff;
      best_score_in = best_score_ff;
      best_mt_in    = best_mt_ff;
      best_tag_in   = best_tag_ff;
      best_bytes_in = best_bytes_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = hi_ff[IW-1:0];
      ram_wdata     = EW'(ld_entry);
      ram_raddr     = rd_ff[IW-1:0];
      total_after   = total_ff - TW'(best_bytes_ff);

      if (csr_we) begin
         if (csr_index == wsce_pkg::CSR_BYTE_LIMIT) begin
            limit_in = csr_wdata;
         end else if (csr_index == wsce_pkg::CSR_POLICY_MODE) begin
            mode_in = csr_wdata[1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.operation)
                  wsce_pkg::OP_LOAD: begin
                     if (hi_ff < CW'(MAX_ENTRIES)) begin
                        ram_we             = 1'b1;
                        live_in[hi_ff[IW-1:0]] = 1'b1;
                        hi_in              = hi_ff + CW'(1);
                        total_in           = total_ff + TW'(req_data.entry_bytes);
                     end
                  end
                  wsce_pkg::OP_CLEAR: begin
                     live_in  = '0;
                     hi_in    = '0;
                     total_in = '0;
                  end
                  wsce_pkg::OP_RUN: begin
                     now_in = req_data.now_seconds;
                     if (limit_ff == 48'd0 || 48'(total_ff) <= limit_ff) begin
                        rsp_valid_in        = 1'b1;
                        rsp_in.victim_tag   = '0;
                        rsp_in.victim_valid = 1'b0;
                        rsp_in.last_of_run  = 1'b1;
                        rsp_in.bytes_left   = sat_bytes(total_ff);
                     end else begin
                        state_in     = ST_SCAN;
                        rd_in        = '0;
                        have_best_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (rd_ff < hi_ff) begin
               p1_valid_in = 1'b1;
               rd_in       = rd_ff + CW'(1);
            end
            s2_valid_in = p1_valid_ff && live_ff[p1_idx_ff];
            // A lower mod_t breaks a score tie; a full tie keeps the earlier slot, the earlier load.
            if (s2_valid_ff && (!have_best_ff || s2_score_ff < best_score_ff ||
                (s2_score_ff == best_score_ff && s2_mt_ff < best_mt_ff))) begin
               have_best_in  = 1'b1;
               best_idx_in   = s2_idx_ff;
               best_score_in = s2_score_ff;
               best_mt_in    = s2_mt_ff;
               best_tag_in   = s2_tag_ff;
               best_bytes_in = s2_bytes_ff;
            end
            if (rd_ff == hi_ff && !p1_valid_ff && !s2_valid_ff) begin
               state_in = ST_EVICT;
            end
         end

         ST_EVICT: begin
            live_in[best_idx_ff] = 1'b0;
            total_in             = total_after;
            rsp_valid_in         = 1'b1;
            rsp_in.victim_tag    = best_tag_ff;
            rsp_in.victim_valid  = 1'b1;
            rsp_in.bytes_left    = sat_bytes(total_after);
            rd_in                = '0;
            have_best_in         = 1'b0;
            if (48'(total_after) <= limit_ff) begin
               rsp_in.last_of_run = 1'b1;
               wr_in              = '0;
               state_in           = ST_COMPACT;
            end else begin
               rsp_in.last_of_run = 1'b0;
               state_in           = ST_SCAN;
            end
         end

         ST_COMPACT: begin
            if (rd_ff < hi_ff) begin
               p1_valid_in = 1'b1;
               rd_in       = rd_ff + CW'(1);
            end
            // The write slot never passes the slot being read, so no overlap occurs.
            if (p1_valid_ff && live_ff[p1_idx_ff]) begin
               ram_we    = 1'b1;
               ram_waddr = wr_ff[IW-1:0];
               ram_wdata = ram_rdata;
               wr_in     = wr_ff + CW'(1);
            end
            if (rd_ff == hi_ff && !p1_valid_ff) begin
               hi_in = wr_ff;
               for (int i = 0; i < MAX_ENTRIES; i++) begin
                  live_in[i] = (CW'(i) < wr_ff);
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= '0;
         mode_ff      <= '0;
         live_ff      <= '0;
         hi_ff        <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         total_ff     <= '0;
         p1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         mode_ff      <= mode_in;
         live_ff      <= live_in;
         hi_ff        <= hi_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         total_ff     <= total_in;
         p1_valid_ff  <= p1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff        <= now_in;
      p1_idx_ff     <= p1_idx_in;
      s2_idx_ff     <= s2_idx_in;
      s2_score_ff   <= s2_score_in;
      s2_mt_ff      <= s2_mt_in;
      s2_tag_ff     <= s2_tag_in;
      s2_bytes_ff   <= s2_bytes_in;
      best_idx_ff   <= best_idx_in;
      best_score_ff <= best_score_in;
      best_mt_ff    <= best_mt_in;
      best_tag_ff   <= best_tag_in;
      best_bytes_ff <= best_bytes_in;
      rsp_ff        <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/sv/weighted_score_cache_evictor_checker.sv
// Checker that watches the evictor's channels, predicts each run's victims and compares them.
module weighted_score_cache_evictor_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  wsce_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  wsce_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [47:0]       csr_wdata,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;

   wsce_pkg::entry_type table_q[DEPTH];
   int                  fill;
   logic [47:0]         limit_reg;
   logic [1:0]          mode_reg;
   wsce_pkg::rsp_type   victims_due[$];

   function automatic longint keep_score(input wsce_pkg::entry_type e, input logic [33:0] now);
      longint     w, mult, rate, age, s;
      logic [33:0] base_t;
      case (e.reason)
         3'd0:    w = 120;
         3'd1:    w = 100;
         3'd2:    w = 55;
         3'd3:    w = 30;
         default: w = 20;
      endcase
      mult = (mode_reg == wsce_pkg::MODE_AGGRESSIVE) ? 27 :
             ((mode_reg == wsce_pkg::MODE_CONSERVATIVE) ? 15 : 20);
      rate = (mode_reg == wsce_pkg::MODE_AGGRESSIVE) ? 7 : 15;
      base_t = (e.used_t != 34'd0) ? e.used_t : e.mod_t;
      age = (now > base_t) ? longint'(now - base_t) : 0;
      s = w * mult * 3600;
      s += longint'(e.plays) * 35 * 72000;
      s += longint'(e.prio) * 12 * 72000;
      if (e.played) s += 90 * 72000;
      if (e.reason == wsce_pkg::REASON_PREFETCH && e.plays == 5'd0) s -= 80 * 72000;
      return s - age * rate;
   endfunction

   function automatic logic [39:0] saturate(input longint unsigned v);
      return (v > longint'(wsce_pkg::BYTES_MAX)) ? wsce_pkg::BYTES_MAX : v[39:0];
   endfunction

   task automatic predict_request(input wsce_pkg::req_type r);
      longint unsigned     total;
      longint              best_s, s;
      int                  best, k;
      wsce_pkg::rsp_type   run_out[DEPTH];
      wsce_pkg::entry_type e;
      case (r.operation)
         wsce_pkg::OP_LOAD: begin
            if (fill < DEPTH) begin
               e.tag    = r.entry_tag;
               e.bytes  = r.entry_bytes;
               e.reason = r.reason_code;
               e.plays  = (r.times_played > 16'd20) ? 5'd20 : r.times_played[4:0];
               e.prio   = r.keep_priority;
               e.used_t = r.used_seconds;
               e.mod_t  = r.modified_seconds;
               e.played = r.was_played;
               table_q[fill] = e;
               fill++;
            end
         end
         wsce_pkg::OP_CLEAR: fill = 0;
         wsce_pkg::OP_RUN: begin
            total = 0;
            k = 0;
            for (int i = 0; i < fill; i++) total += table_q[i].bytes;
            if (limit_reg == 48'd0 || total <= limit_reg) begin
               run_out[0] = '{victim_tag: 32'd0, victim_valid: 1'b0, last_of_run: 1'b1,
                              bytes_left: saturate(total)};
               k = 1;
            end else begin
               while (total > limit_reg && fill > 0) begin
                  best = 0;
                  best_s = keep_score(table_q[0], r.now_seconds);
                  for (int i = 1; i < fill; i++) begin
                     s = keep_score(table_q[i], r.now_seconds);
                     if (s < best_s ||
                         (s == best_s && table_q[i].mod_t < table_q[best].mod_t)) begin
                        best = i;
                        best_s = s;
                     end
                  end
                  total -= table_q[best].bytes;
                  run_out[k] = '{victim_tag: table_q[best].tag, victim_valid: 1'b1,
                                 last_of_run: 1'b0, bytes_left: saturate(total)};
                  k++;
                  // Later slots shift down so load order is kept.
                  for (int i = best; i < fill - 1; i++) table_q[i] = table_q[i + 1];
                  fill--;
               end
               run_out[k - 1].last_of_run = 1'b1;
            end
            for (int i = 0; i < k; i++) victims_due.insert(victims_due.size(), run_out[i]);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill <= 0;
         limit_reg <= '0;
         mode_reg <= '0;
         victims_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == wsce_pkg::CSR_BYTE_LIMIT) limit_reg = csr_wdata;
            else if (csr_index == wsce_pkg::CSR_POLICY_MODE) mode_reg = csr_wdata[1:0];
         end
         if (rsp_valid) begin
            if (victims_due.size() == 0) begin
               $display("%0t: unexpected result tag=%h valid=%b last=%b left=%h", $time,
                        rsp_data.victim_tag, rsp_data.victim_valid, rsp_data.last_of_run,
                        rsp_data.bytes_left);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_data !== victims_due[0]) begin
                  $display("%0t: expected tag=%h valid=%b last=%b left=%h, got tag=%h valid=%b last=%b left=%h",
                           $time, victims_due[0].victim_tag, victims_due[0].victim_valid,
                           victims_due[0].last_of_run, victims_due[0].bytes_left,
                           rsp_data.victim_tag, rsp_data.victim_valid, rsp_data.last_of_run,
                           rsp_data.bytes_left);
                  fail_count <= fail_count + 1;
               end
               void'(victims_due.pop_front());
            end
         end
         if (start && !busy) predict_request(req_data);
      end
   end

   assign pending_count = victims_due.size();

endmodule

>>> tb/sv/weighted_score_cache_evictor_tb.sv
// Top of the evictor testbench: clock, reset, request and register stimulus, and the verdict.
module weighted_score_cache_evictor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 20000;

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam logic [1:0] MODE_BALANCED = 2'd0;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   wsce_pkg::req_type req_data = '0;
   logic              rsp_valid;
   wsce_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = wsce_pkg::CSR_BYTE_LIMIT;
   logic [47:0]       csr_wdata = '0;
   int                fail_count;
   int                pending_count;
   int                idle_pct = 36;
   int                quiet_cycles = 0;
   logic [33:0]       epoch = 34'h1_0000_0000;

   weighted_score_cache_evictor dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   weighted_score_cache_evictor_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Drives one request and returns at the falling edge after it was taken.
   task automatic send(input wsce_pkg::req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data = r;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // Waits until every run has finished and the compaction pass is surely over.
   task automatic settle();
      start = 1'b0;
      @(negedge clock);
      while (pending_count != 0 || busy) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [47:0] value);
      settle();
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic wsce_pkg::req_type load_req(input logic [39:0] bytes);
      wsce_pkg::req_type r;
      r.operation        = wsce_pkg::OP_LOAD;
      r.entry_tag        = $urandom;
      r.entry_bytes      = bytes;
      r.reason_code      = 3'($urandom_range(0, 7));
      r.times_played     = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 25)) : 16'($urandom);
      r.keep_priority    = 8'($urandom);
      r.used_seconds     = ($urandom_range(0, 3) == 0) ? 34'd0 :
                           epoch - 34'($urandom_range(0, 200000));
      r.modified_seconds = ($urandom_range(0, 4) == 0) ? epoch :
                           epoch - 34'($urandom_range(0, 200000));
      if ($urandom_range(0, 9) == 0) begin
         r.used_seconds     = {$urandom, 2'($urandom)};
         r.modified_seconds = {$urandom, 2'($urandom)};
      end
      r.was_played       = 1'($urandom_range(0, 1));
      r.now_seconds      = {$urandom, 2'($urandom)};
      return r;
   endfunction

   function automatic logic [39:0] random_bytes();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return 40'($urandom_range(1, 4000));
      if (pick < 9) return {8'($urandom), 32'($urandom)};
      return 40'd0;
   endfunction

   function automatic wsce_pkg::req_type op_req(input logic [1:0] op, input logic [33:0] now);
      wsce_pkg::req_type r;
      r = load_req(random_bytes());
      r.operation = op;
      r.now_seconds = now;
      return r;
   endfunction

   function automatic logic [33:0] random_now();
      if ($urandom_range(0, 9) == 0) return {$urandom, 2'($urandom)};
      return epoch + 34'($urandom_range(0, 300000)) - 34'd1000;
   endfunction

   initial begin
      wsce_pkg::req_type r;
      int                items;
      logic [47:0]       limits[8];
      logic [1:0]        modes[8];

      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed: field extremes with eviction off, then a forced eviction sweep.
      send(op_req(wsce_pkg::OP_RUN, 34'd0));
      r = load_req(wsce_pkg::BYTES_MAX);
      r.entry_tag = 32'hFFFF_FFFF; r.keep_priority = 8'sh7F; r.times_played = 16'hFFFF;
      r.reason_code = 3'd7; r.used_seconds = 34'd0; r.modified_seconds = 34'h3_FFFF_FFFF;
      send(r);
      r = load_req(wsce_pkg::BYTES_MAX);
      r.entry_tag = 32'd0; r.keep_priority = -8'sd128; r.times_played = 16'd0;
      r.reason_code = wsce_pkg::REASON_PREFETCH; r.was_played = 1'b0;
      send(r);
      r = load_req(40'd0);
      r.reason_code = wsce_pkg::REASON_PREFETCH; r.times_played = 16'd3;
      send(r);
      // Two entries alike but for the tag: the tie goes to the earlier load.
      r = load_req(40'd100);
      send(r);
      r.entry_tag = r.entry_tag ^ 32'h1;
      send(r);
      send(op_req(OP_UNUSED, 34'd0));
      send(op_req(wsce_pkg::OP_RUN, 34'h3_FFFF_FFFF));
      write_csr(wsce_pkg::CSR_BYTE_LIMIT, 48'd1);
      write_csr(wsce_pkg::CSR_POLICY_MODE, 48'(wsce_pkg::MODE_AGGRESSIVE));
      send(op_req(wsce_pkg::OP_RUN, 34'h3_FFFF_FFFF));
      send(op_req(wsce_pkg::OP_CLEAR, 34'd0));
      for (int i = 0; i < 4; i++) send(load_req(40'($urandom_range(1, 50))));
      send(op_req(wsce_pkg::OP_RUN, 34'd0));
      send(op_req(wsce_pkg::OP_CLEAR, 34'd0));
      send(op_req(wsce_pkg::OP_RUN, epoch));

      limits = '{48'd0, 48'd6000, 48'd1, 48'hFFFF_FFFF_FFFF, 48'd20000, 48'd2500,
                 48'($urandom), 48'd1};
      modes  = '{MODE_BALANCED, wsce_pkg::MODE_CONSERVATIVE, wsce_pkg::MODE_AGGRESSIVE,
                 MODE_UNUSED, MODE_BALANCED, wsce_pkg::MODE_CONSERVATIVE,
                 wsce_pkg::MODE_AGGRESSIVE, MODE_BALANCED};
      for (int p = 0; p < 8; p++) begin
         write_csr(wsce_pkg::CSR_BYTE_LIMIT, limits[p]);
         write_csr(wsce_pkg::CSR_POLICY_MODE, 48'(modes[p]));
         idle_pct = (p == 2) ? 0 : 36;
         if (p == 7) begin
            // Overfill the table, then evict down to the byte limit in one run.
            send(op_req(wsce_pkg::OP_CLEAR, 34'd0));
            for (int i = 0; i < 66; i++) send(load_req(random_bytes()));
            send(op_req(wsce_pkg::OP_RUN, random_now()));
         end else begin
            items = 0;
            while (items < 32) begin
               if ($urandom_range(0, 9) < 3) begin
                  send(op_req(wsce_pkg::OP_CLEAR, 34'd0));
                  items++;
               end
               for (int i = $urandom_range(1, 8); i > 0; i--) begin
                  send(load_req(random_bytes()));
                  items++;
               end
               if ($urandom_range(0, 9) == 0) begin
                  send(op_req(OP_UNUSED, random_now()));
                  items++;
               end
               send(op_req(wsce_pkg::OP_RUN, random_now()));
               items++;
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/wsce_pkg.sv
rtl/wsce_ram.sv
rtl/weighted_score_cache_evictor.sv
tb/sv/weighted_score_cache_evictor_checker.sv
tb/sv/weighted_score_cache_evictor_tb.sv
